@@ rtl/etw_pkg.sv @@
// ----------------------------------------------------------------------------
// etw_pkg
// shared fixed point constants, easing mode codes and register indexes
// ----------------------------------------------------------------------------
package etw_pkg;

    localparam int QW = 32;

    localparam logic signed [QW-1:0] Q_ONE    = 32'sd65536;
    localparam logic signed [QW-1:0] Q_HALF   = 32'sd32768;
    localparam logic signed [QW-1:0] B_SCALE  = 32'sd495616;
    localparam logic signed [QW-1:0] B_OFF1   = 32'sd35747;
    localparam logic signed [QW-1:0] B_OFF2   = 32'sd53620;
    localparam logic signed [QW-1:0] B_OFF3   = 32'sd62557;
    localparam logic signed [QW-1:0] B_ADD1   = 32'sd49152;
    localparam logic signed [QW-1:0] B_ADD2   = 32'sd61440;
    localparam logic signed [QW-1:0] B_ADD3   = 32'sd64512;
    localparam logic signed [QW-1:0] BK_S     = 32'sd111514;
    localparam logic signed [QW-1:0] BK_S1    = 32'sd177050;
    localparam logic signed [QW-1:0] EL_SHIFT = 32'sd4915;
    localparam logic signed [QW-1:0] EL_FREQ  = 32'sd1371887;
    localparam logic signed [QW-1:0] Q_2PI    = 32'sd411775;
    localparam logic signed [QW-1:0] Q_PI     = 32'sd205887;
    localparam logic signed [QW-1:0] Q_PI2    = 32'sd102944;
    localparam logic signed [QW-1:0] Q_3PI2   = 32'sd308831;
    localparam logic signed [QW-1:0] Q_LN2    = 32'sd45426;

    // sine and exponent polynomial coefficients
    localparam logic signed [QW-1:0] SIN_C7 = -32'sd13;
    localparam logic signed [QW-1:0] SIN_C5 = 32'sd546;
    localparam logic signed [QW-1:0] SIN_C3 = 32'sd10923;
    localparam logic signed [QW-1:0] EXP_C5 = 32'sd546;
    localparam logic signed [QW-1:0] EXP_C4 = 32'sd2731;
    localparam logic signed [QW-1:0] EXP_C3 = 32'sd10923;
    localparam logic signed [QW-1:0] EXP_C2 = 32'sd32768;

    // easing modes
    localparam logic [3:0] MODE_LINEAR     = 4'd0;
    localparam logic [3:0] MODE_CUBIC_IN   = 4'd1;
    localparam logic [3:0] MODE_CUBIC_OUT  = 4'd2;
    localparam logic [3:0] MODE_BOUNCE_IN  = 4'd3;
    localparam logic [3:0] MODE_BOUNCE_OUT = 4'd4;
    localparam logic [3:0] MODE_BACK_IN    = 4'd5;
    localparam logic [3:0] MODE_BACK_OUT   = 4'd6;
    localparam logic [3:0] MODE_ELAST_IN   = 4'd7;
    localparam logic [3:0] MODE_ELAST_OUT  = 4'd8;
    localparam logic [3:0] MODE_CUBIC_IO   = 4'd9;
    localparam logic [3:0] MODE_CUBIC_OI   = 4'd10;
    localparam logic [3:0] MODE_ELAST_OI   = 4'd11;
    localparam logic [3:0] MODE_ELAST_IO   = 4'd12;

    // register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_REVERSE = 2'd1;
    localparam logic [1:0] REG_REPEAT  = 2'd2;

    localparam logic REQ_START = 1'b1;

endpackage

@@ rtl/easing_tween_engine.sv @@
// ----------------------------------------------------------------------------
// easing_tween_engine
// time driven value tween with selectable easing curves, q16 fixed point
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready) carries one request per transfer:
//   req_type 1 starts a tween, req_type 0 is an update tick with now_ms
//   out channel (out_valid/out_ready) returns exactly one result per request
//   start, finished and cycle end requests go through the push state to
//   the output register and skip the datapath; a running update first runs
//   a restoring division for the ratio, then works through its curve terms
//   on the one shared q16 multiplier (elastic curves with angle reduction
//   are the longest path)
//   in_ready is high only while the sequencer is idle; a finished result
//   waits in the output register, so the next request is taken while the
//   receiver stalls, and a second result waits in the push state
//   the apb port writes easing_mode, reverse_enable and repeat_setting;
//   writing repeat_setting also reloads the repeat counter
//   reset leaves the engine finished, mode linear, repeat count one
// ----------------------------------------------------------------------------
module easing_tween_engine
    import etw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic        [31:0] now_ms,
    input  logic signed [15:0] from_value,
    input  logic signed [15:0] to_value,
    input  logic        [31:0] duration_ms,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_value,
    output logic               value_valid,
    output logic               still_running,
    output logic               repeat_event,
    output logic               finish_event,
    output logic               start_rejected,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    // sequencer states
    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_DIV  = 6'd1;
    localparam logic [5:0] S_SEL  = 6'd2;
    localparam logic [5:0] S_DISP = 6'd3;
    localparam logic [5:0] S_C_A  = 6'd4;
    localparam logic [5:0] S_C_B  = 6'd5;
    localparam logic [5:0] S_C_C  = 6'd6;
    localparam logic [5:0] S_B_A  = 6'd7;
    localparam logic [5:0] S_B_B  = 6'd8;
    localparam logic [5:0] S_B_C  = 6'd9;
    localparam logic [5:0] S_E_A  = 6'd10;
    localparam logic [5:0] S_E_B  = 6'd11;
    localparam logic [5:0] S_E_R  = 6'd12;
    localparam logic [5:0] S_E_F  = 6'd13;
    localparam logic [5:0] S_E_1  = 6'd14;
    localparam logic [5:0] S_E_2  = 6'd15;
    localparam logic [5:0] S_E_3  = 6'd16;
    localparam logic [5:0] S_E_4  = 6'd17;
    localparam logic [5:0] S_E_5  = 6'd18;
    localparam logic [5:0] S_X_1  = 6'd19;
    localparam logic [5:0] S_X_2  = 6'd20;
    localparam logic [5:0] S_X_3  = 6'd21;
    localparam logic [5:0] S_X_4  = 6'd22;
    localparam logic [5:0] S_X_5  = 6'd23;
    localparam logic [5:0] S_X_6  = 6'd24;
    localparam logic [5:0] S_X_7  = 6'd25;
    localparam logic [5:0] S_CMB  = 6'd26;
    localparam logic [5:0] S_INT  = 6'd27;
    localparam logic [5:0] S_OUT  = 6'd28;
    localparam logic [5:0] S_PUSH = 6'd29;

    logic [5:0] state_reg;

    // configuration registers
    logic [3:0] easing_mode_reg;
    logic       reverse_enable_reg;
    logic [7:0] repeat_setting_reg;

    // tween state
    logic signed [15:0] begin_value_reg;
    logic signed [15:0] final_value_reg;
    logic        [31:0] begin_time_reg;
    logic        [31:0] span_time_reg;
    logic        [7:0]  repeats_left_reg;
    logic               done_flag_reg;

    // datapath working registers
    logic        [32:0] rem_reg;
    logic        [15:0] quo_reg;
    logic        [3:0]  cnt_reg;
    logic signed [31:0] rr_reg;
    logic signed [31:0] t0_reg;
    logic signed [31:0] t1_reg;
    logic signed [31:0] t2_reg;
    logic signed [31:0] cc_reg;
    logic        [19:0] mm_reg;
    logic        [3:0]  whole_reg;
    logic        [3:0]  bmode_reg;
    logic               combo_reg;
    logic               second_reg;

    // pending result
    logic signed [15:0] res_value_reg;
    logic               res_valid_reg;
    logic               res_running_reg;
    logic               res_repeat_reg;
    logic               res_finish_reg;
    logic               res_reject_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] out_value_reg;
    logic               value_valid_reg;
    logic               still_running_reg;
    logic               repeat_event_reg;
    logic               finish_event_reg;
    logic               start_rejected_reg;

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] mp;

    etw_qmul u_qmul
    (
        .a (mul_a),
        .b (mul_b),
        .y (mp)
    );

    logic               cfg_write;
    logic               in_xfer;
    logic               out_free;
    logic        [32:0] end_sum;
    logic        [31:0] elapsed;
    logic        [32:0] rem_sh;
    logic signed [31:0] u_op;
    logic signed [31:0] xb;
    logic        [20:0] x11;
    logic        [19:0] m_w;
    logic signed [31:0] diff;
    logic signed [32:0] sum_val;
    logic        [16:0] r2;
    logic signed [31:0] ob;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:    prdata = {28'd0, easing_mode_reg};
            REG_REVERSE: prdata = {31'd0, reverse_enable_reg};
            REG_REPEAT:  prdata = {24'd0, repeat_setting_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        end_sum = {1'b0, now_ms} + {1'b0, duration_ms};
        elapsed = now_ms - begin_time_reg;
        rem_sh  = {rem_reg[31:0], 1'b0};
        r2      = {quo_reg, 1'b0};
        diff    = 32'(final_value_reg) - 32'(begin_value_reg);
        sum_val = 33'(begin_value_reg) + 33'(t0_reg);
        ob      = mp + t2_reg;
        // cubic and back take r or r - 1 depending on direction
        if (bmode_reg == MODE_CUBIC_IN || bmode_reg == MODE_BACK_IN)
            u_op = rr_reg;
        else
            u_op = rr_reg - Q_ONE;
        // bounce in mirrors the ratio
        if (bmode_reg == MODE_BOUNCE_IN)
            xb = Q_ONE - rr_reg;
        else
            xb = rr_reg;
        x11 = 21'(xb[16:0]) * 21'd11;
        // exponent magnitude, ten times the ratio for elastic out, ten times its distance from one for elastic in
        if (bmode_reg == MODE_ELAST_IN)
            m_w = 20'(17'(Q_ONE - rr_reg)) * 20'd10;
        else
            m_w = 20'(rr_reg[16:0]) * 20'd10;
    end

    // multiplier operand selection per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_C_A:
            begin
                mul_a = u_op;
                mul_b = u_op;
            end
            S_C_B:
            begin
                if (bmode_reg == MODE_CUBIC_IN || bmode_reg == MODE_CUBIC_OUT)
                    mul_a = t0_reg;
                else
                    mul_a = BK_S1;
                mul_b = u_op;
            end
            S_C_C:
            begin
                mul_a = t0_reg;
                mul_b = t1_reg;
            end
            S_B_B:
            begin
                mul_a = t0_reg;
                mul_b = t0_reg;
            end
            S_B_C:
            begin
                mul_a = B_SCALE;
                mul_b = t0_reg;
            end
            S_E_B:
            begin
                mul_a = t0_reg;
                mul_b = EL_FREQ;
            end
            S_E_1:
            begin
                mul_a = t2_reg;
                mul_b = t2_reg;
            end
            S_E_2:
            begin
                mul_a = SIN_C7;
                mul_b = t0_reg;
            end
            S_E_3, S_E_4, S_X_3, S_X_4, S_X_5, S_X_6:
            begin
                mul_a = t1_reg;
                mul_b = t0_reg;
            end
            S_E_5, S_X_7:
            begin
                mul_a = t1_reg;
                mul_b = t2_reg;
            end
            S_X_1:
            begin
                mul_a = 32'(mm_reg);
                mul_b = Q_LN2;
            end
            S_X_2:
            begin
                mul_a = EXP_C5;
                mul_b = t0_reg;
            end
            S_CMB:
            begin
                mul_a = cc_reg;
                mul_b = Q_HALF;
            end
            S_INT:
            begin
                mul_a = diff;
                mul_b = cc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            easing_mode_reg    <= MODE_LINEAR;
            reverse_enable_reg <= 1'b0;
            repeat_setting_reg <= 8'd1;
            begin_value_reg    <= '0;
            final_value_reg    <= '0;
            begin_time_reg     <= '0;
            span_time_reg      <= '0;
            repeats_left_reg   <= 8'd1;
            done_flag_reg      <= 1'b1;
            out_valid_reg      <= 1'b0;
            cnt_reg            <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_MODE:    easing_mode_reg <= pwdata[3:0];
                    REG_REVERSE: reverse_enable_reg <= pwdata[0];
                    REG_REPEAT:
                    begin
                        repeat_setting_reg <= pwdata[7:0];
                        repeats_left_reg   <= pwdata[7:0];
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        res_value_reg   <= '0;
                        res_valid_reg   <= 1'b0;
                        res_running_reg <= 1'b0;
                        res_repeat_reg  <= 1'b0;
                        res_finish_reg  <= 1'b0;
                        res_reject_reg  <= 1'b0;
                        state_reg       <= S_PUSH;
                        if (req_type == REQ_START)
                        begin
                            if (end_sum[32])
                                res_reject_reg <= 1'b1;
                            else
                            begin
                                begin_value_reg <= from_value;
                                final_value_reg <= to_value;
                                begin_time_reg  <= now_ms;
                                span_time_reg   <= duration_ms;
                                done_flag_reg   <= 1'b0;
                                res_value_reg   <= from_value;
                                res_valid_reg   <= 1'b1;
                            end
                        end
                        else if (!done_flag_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            if (elapsed >= span_time_reg)
                            begin
                                // cycle end: land on the end value
                                res_value_reg <= final_value_reg;
                                if (reverse_enable_reg)
                                begin
                                    begin_value_reg <= final_value_reg;
                                    final_value_reg <= begin_value_reg;
                                end
                                if (repeats_left_reg != 8'd1)
                                begin
                                    if (repeats_left_reg > 8'd1)
                                        repeats_left_reg <= repeats_left_reg - 8'd1;
                                    begin_time_reg  <= now_ms;
                                    res_repeat_reg  <= 1'b1;
                                    res_running_reg <= 1'b1;
                                end
                                else
                                begin
                                    res_finish_reg <= 1'b1;
                                    done_flag_reg  <= 1'b1;
                                end
                            end
                            else
                            begin
                                rem_reg   <= {1'b0, elapsed};
                                quo_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                    end
                end

                // ratio = elapsed * 2^16 / span, one quotient bit a cycle
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, span_time_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, span_time_reg};
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= S_SEL;
                end

                // pick base curve and its argument, splitting in-out modes
                S_SEL:
                begin
                    combo_reg  <= 1'b0;
                    second_reg <= 1'b0;
                    bmode_reg  <= easing_mode_reg;
                    rr_reg     <= 32'(quo_reg);
                    if (easing_mode_reg inside {[MODE_CUBIC_IO:MODE_ELAST_IO]})
                    begin
                        combo_reg <= 1'b1;
                        if (!quo_reg[15])
                        begin
                            rr_reg <= 32'(r2);
                            case (easing_mode_reg)
                                MODE_CUBIC_IO: bmode_reg <= MODE_CUBIC_IN;
                                MODE_CUBIC_OI: bmode_reg <= MODE_CUBIC_OUT;
                                MODE_ELAST_OI: bmode_reg <= MODE_ELAST_OUT;
                                default:       bmode_reg <= MODE_ELAST_IN;
                            endcase
                        end
                        else
                        begin
                            second_reg <= 1'b1;
                            rr_reg     <= 32'(r2) - Q_ONE;
                            case (easing_mode_reg)
                                MODE_CUBIC_IO: bmode_reg <= MODE_CUBIC_OUT;
                                MODE_CUBIC_OI: bmode_reg <= MODE_CUBIC_IN;
                                MODE_ELAST_OI: bmode_reg <= MODE_ELAST_IN;
                                default:       bmode_reg <= MODE_ELAST_OUT;
                            endcase
                        end
                    end
                    state_reg <= S_DISP;
                end

                S_DISP:
                begin
                    case (bmode_reg)
                        MODE_LINEAR:
                        begin
                            cc_reg    <= rr_reg;
                            state_reg <= S_CMB;
                        end
                        MODE_CUBIC_IN, MODE_CUBIC_OUT, MODE_BACK_IN, MODE_BACK_OUT:
                            state_reg <= S_C_A;
                        MODE_BOUNCE_IN, MODE_BOUNCE_OUT:
                            state_reg <= S_B_A;
                        MODE_ELAST_IN, MODE_ELAST_OUT:
                        begin
                            if (rr_reg == 32'sd0)
                            begin
                                cc_reg    <= '0;
                                state_reg <= S_CMB;
                            end
                            else
                                state_reg <= S_E_A;
                        end
                        default:
                        begin
                            cc_reg    <= Q_ONE;
                            state_reg <= S_CMB;
                        end
                    endcase
                end

                S_C_A:
                begin
                    t0_reg    <= mp;
                    state_reg <= S_C_B;
                end

                S_C_B:
                begin
                    case (bmode_reg)
                        MODE_CUBIC_IN:
                        begin
                            cc_reg    <= mp;
                            state_reg <= S_CMB;
                        end
                        MODE_CUBIC_OUT:
                        begin
                            cc_reg    <= mp + Q_ONE;
                            state_reg <= S_CMB;
                        end
                        MODE_BACK_IN:
                        begin
                            t1_reg    <= mp - BK_S;
                            state_reg <= S_C_C;
                        end
                        default:
                        begin
                            t1_reg    <= mp + BK_S;
                            state_reg <= S_C_C;
                        end
                    endcase
                end

                S_C_C:
                begin
                    if (bmode_reg == MODE_BACK_OUT)
                        cc_reg <= mp + Q_ONE;
                    else
                        cc_reg <= mp;
                    state_reg <= S_CMB;
                end

                // bounce segment selection, exact against multiples of 1/11
                S_B_A:
                begin
                    if (x11 < 21'd262144)
                    begin
                        t0_reg <= xb;
                        t2_reg <= '0;
                    end
                    else if (x11 < 21'd524288)
                    begin
                        t0_reg <= xb - B_OFF1;
                        t2_reg <= B_ADD1;
                    end
                    else if (x11 < 21'd655360)
                    begin
                        t0_reg <= xb - B_OFF2;
                        t2_reg <= B_ADD2;
                    end
                    else
                    begin
                        t0_reg <= xb - B_OFF3;
                        t2_reg <= B_ADD3;
                    end
                    state_reg <= S_B_B;
                end

                S_B_B:
                begin
                    t0_reg    <= mp;
                    state_reg <= S_B_C;
                end

                S_B_C:
                begin
                    if (bmode_reg == MODE_BOUNCE_IN)
                        cc_reg <= Q_ONE - ob;
                    else
                        cc_reg <= ob;
                    state_reg <= S_CMB;
                end

                // elastic: sine argument and exponent split
                S_E_A:
                begin
                    if (bmode_reg == MODE_ELAST_IN)
                        t0_reg <= rr_reg - Q_ONE - EL_SHIFT;
                    else
                        t0_reg <= rr_reg - EL_SHIFT;
                    if (m_w[15:0] != 16'd0)
                    begin
                        whole_reg <= m_w[19:16] + 4'd1;
                        mm_reg    <= 20'(17'h10000 - {1'b0, m_w[15:0]});
                    end
                    else
                    begin
                        whole_reg <= m_w[19:16];
                        mm_reg    <= '0;
                    end
                    state_reg <= S_E_B;
                end

                S_E_B:
                begin
                    t2_reg    <= mp;
                    state_reg <= S_E_R;
                end

                // angle into [0, 2pi) by repeated add or subtract
                S_E_R:
                begin
                    if (t2_reg < 32'sd0)
                        t2_reg <= t2_reg + Q_2PI;
                    else if (t2_reg >= Q_2PI)
                        t2_reg <= t2_reg - Q_2PI;
                    else
                        state_reg <= S_E_F;
                end

                S_E_F:
                begin
                    if (t2_reg < Q_PI2)
                        t2_reg <= t2_reg;
                    else if (t2_reg < Q_3PI2)
                        t2_reg <= Q_PI - t2_reg;
                    else
                        t2_reg <= t2_reg - Q_2PI;
                    state_reg <= S_E_1;
                end

                S_E_1:
                begin
                    t0_reg    <= mp;
                    state_reg <= S_E_2;
                end

                S_E_2:
                begin
                    t1_reg    <= mp + SIN_C5;
                    state_reg <= S_E_3;
                end

                S_E_3:
                begin
                    t1_reg    <= mp - SIN_C3;
                    state_reg <= S_E_4;
                end

                S_E_4:
                begin
                    t1_reg    <= mp + Q_ONE;
                    state_reg <= S_E_5;
                end

                S_E_5:
                begin
                    t2_reg    <= mp;
                    state_reg <= S_X_1;
                end

                // 2^f polynomial, then shift by the whole part
                S_X_1:
                begin
                    t0_reg    <= mp;
                    state_reg <= S_X_2;
                end

                S_X_2:
                begin
                    t1_reg    <= mp + EXP_C4;
                    state_reg <= S_X_3;
                end

                S_X_3:
                begin
                    t1_reg    <= mp + EXP_C3;
                    state_reg <= S_X_4;
                end

                S_X_4:
                begin
                    t1_reg    <= mp + EXP_C2;
                    state_reg <= S_X_5;
                end

                S_X_5:
                begin
                    t1_reg    <= mp + Q_ONE;
                    state_reg <= S_X_6;
                end

                S_X_6:
                begin
                    t1_reg    <= (mp + Q_ONE) >>> whole_reg;
                    state_reg <= S_X_7;
                end

                S_X_7:
                begin
                    if (bmode_reg == MODE_ELAST_IN)
                        cc_reg <= -mp;
                    else
                        cc_reg <= mp + Q_ONE;
                    state_reg <= S_CMB;
                end

                // halve for in-out combinations, lifting the second half by one half
                S_CMB:
                begin
                    if (combo_reg)
                    begin
                        if (second_reg)
                            cc_reg <= mp + Q_HALF;
                        else
                            cc_reg <= mp;
                    end
                    state_reg <= S_INT;
                end

                S_INT:
                begin
                    t0_reg    <= mp;
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (sum_val > 33'sd32767)
                        res_value_reg <= 16'sh7fff;
                    else if (sum_val < -33'sd32768)
                        res_value_reg <= 16'sh8000;
                    else
                        res_value_reg <= sum_val[15:0];
                    res_running_reg <= 1'b1;
                    state_reg       <= S_PUSH;
                end

                S_PUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_value_reg      <= res_value_reg;
                        value_valid_reg    <= res_valid_reg;
                        still_running_reg  <= res_running_reg;
                        repeat_event_reg   <= res_repeat_reg;
                        finish_event_reg   <= res_finish_reg;
                        start_rejected_reg <= res_reject_reg;
                        state_reg          <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_value      = out_value_reg;
    assign value_valid    = value_valid_reg;
    assign still_running  = still_running_reg;
    assign repeat_event   = repeat_event_reg;
    assign finish_event   = finish_event_reg;
    assign start_rejected = start_rejected_reg;

endmodule

@@ rtl/etw_qmul.sv @@
// ----------------------------------------------------------------------------
// etw_qmul
// shared q16 multiplier, rounds to nearest with ties away from zero
// ----------------------------------------------------------------------------
module etw_qmul
    import etw_pkg::*;
(
    input  logic signed [QW-1:0] a,
    input  logic signed [QW-1:0] b,
    output logic signed [QW-1:0] y
);

    logic signed [2*QW-1:0] prod;
    logic        [2*QW-1:0] mag;
    logic        [2*QW-1:0] rnd;

    always_comb
    begin
        prod = a * b;
        mag  = prod[2*QW-1] ? (-prod) : prod;
        rnd  = (mag + {{QW{1'b0}}, Q_HALF}) >> 16;
        y    = prod[2*QW-1] ? (-rnd[QW-1:0]) : rnd[QW-1:0];
    end

endmodule

@@ tb/sv/easing_tween_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easing_tween_checker
// watches the request, result and apb channels, predicts each result from
// its own copy of the tween state and compares it field by field
// ----------------------------------------------------------------------------
module easing_tween_checker
    import etw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               req_type,
    input  logic        [31:0] now_ms,
    input  logic signed [15:0] from_value,
    input  logic signed [15:0] to_value,
    input  logic        [31:0] duration_ms,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] out_value,
    input  logic               value_valid,
    input  logic               still_running,
    input  logic               repeat_event,
    input  logic               finish_event,
    input  logic               start_rejected,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] value;
        logic               written;
        logic               running;
        logic               repeated;
        logic               finished;
        logic               rejected;
    } tween_result_t;

    tween_result_t tween_results_due[$];

    logic [3:0]         curve_mode;
    logic               swap_ends;
    logic signed [15:0] from_level;
    logic signed [15:0] to_level;
    logic [31:0]        start_stamp;
    logic [31:0]        span;
    logic [7:0]         laps_left;
    logic               idle_tween;

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0)
            return (p + Q_HALF) / Q_ONE;
        return -((-p + Q_HALF) / Q_ONE);
    endfunction

    function automatic longint fx_sin(longint a);
        longint x, y, y2, p;
        x = a % Q_2PI;
        if (x < 0)
            x += Q_2PI;
        if (x < Q_PI2)
            y = x;
        else if (x < Q_3PI2)
            y = Q_PI - x;
        else
            y = x - Q_2PI;
        y2 = fx_mul(y, y);
        p = fx_mul(SIN_C7, y2) + SIN_C5;
        p = fx_mul(p, y2) - SIN_C3;
        p = fx_mul(p, y2) + Q_ONE;
        return fx_mul(p, y);
    endfunction

    // 2 to the power e for e <= 0
    function automatic longint fx_pow2_neg(longint e);
        longint unsigned m, whole, frac;
        longint f, g, p;
        m = -e;
        whole = m >> 16;
        frac = m & 64'hFFFF;
        if (frac != 0)
        begin
            whole += 1;
            f = Q_ONE - longint'(frac);
        end
        else
            f = 0;
        g = fx_mul(f, Q_LN2);
        p = fx_mul(EXP_C5, g) + EXP_C4;
        p = fx_mul(p, g) + EXP_C3;
        p = fx_mul(p, g) + EXP_C2;
        p = fx_mul(p, g) + Q_ONE;
        p = fx_mul(p, g) + Q_ONE;
        if (whole > 40)
            return 0;
        return p >> whole;
    endfunction

    function automatic longint bounce_out(longint r);
        longint d;
        if (r * 11 < 4 * longint'(Q_ONE))
            return fx_mul(B_SCALE, fx_mul(r, r));
        if (r * 11 < 8 * longint'(Q_ONE))
        begin
            d = r - B_OFF1;
            return fx_mul(B_SCALE, fx_mul(d, d)) + B_ADD1;
        end
        if (r * 11 < 10 * longint'(Q_ONE))
        begin
            d = r - B_OFF2;
            return fx_mul(B_SCALE, fx_mul(d, d)) + B_ADD2;
        end
        d = r - B_OFF3;
        return fx_mul(B_SCALE, fx_mul(d, d)) + B_ADD3;
    endfunction

    function automatic longint simple_curve(logic [3:0] mode, longint r);
        longint i;
        i = r - Q_ONE;
        case (mode)
            MODE_LINEAR:     return r;
            MODE_CUBIC_IN:   return fx_mul(fx_mul(r, r), r);
            MODE_CUBIC_OUT:  return fx_mul(fx_mul(i, i), i) + Q_ONE;
            MODE_BOUNCE_IN:  return Q_ONE - bounce_out(Q_ONE - r);
            MODE_BOUNCE_OUT: return bounce_out(r);
            MODE_BACK_IN:    return fx_mul(fx_mul(r, r), fx_mul(BK_S1, r) - BK_S);
            MODE_BACK_OUT:   return fx_mul(fx_mul(i, i), fx_mul(BK_S1, i) + BK_S) + Q_ONE;
            MODE_ELAST_IN:
            begin
                if (r == 0)
                    return 0;
                return -fx_mul(fx_pow2_neg(10 * i), fx_sin(fx_mul(i - EL_SHIFT, EL_FREQ)));
            end
            MODE_ELAST_OUT:
            begin
                if (r == 0)
                    return 0;
                return fx_mul(fx_pow2_neg(-10 * r), fx_sin(fx_mul(r - EL_SHIFT, EL_FREQ)))
                       + Q_ONE;
            end
            default:         return Q_ONE;
        endcase
    endfunction

    // two half curves glued at the midpoint
    function automatic longint split_curve(logic [3:0] lo, logic [3:0] hi, longint r);
        if (r < Q_HALF)
            return fx_mul(simple_curve(lo, 2 * r), Q_HALF);
        return fx_mul(simple_curve(hi, 2 * r - Q_ONE), Q_HALF) + Q_HALF;
    endfunction

    function automatic longint eased_ratio(logic [3:0] mode, longint r);
        case (mode)
            MODE_CUBIC_IO: return split_curve(MODE_CUBIC_IN, MODE_CUBIC_OUT, r);
            MODE_CUBIC_OI: return split_curve(MODE_CUBIC_OUT, MODE_CUBIC_IN, r);
            MODE_ELAST_OI: return split_curve(MODE_ELAST_OUT, MODE_ELAST_IN, r);
            MODE_ELAST_IO: return split_curve(MODE_ELAST_IN, MODE_ELAST_OUT, r);
            default:       return simple_curve(mode, r);
        endcase
    endfunction

    // advances the tween state by one request and returns its result
    function automatic tween_result_t advance_tween(logic is_start, logic [31:0] now,
                                                    logic signed [15:0] from_v,
                                                    logic signed [15:0] to_v,
                                                    logic [31:0] dur);
        tween_result_t res;
        logic [31:0] elapsed;
        logic signed [15:0] held;
        longint ratio, val;
        res = '0;
        if (is_start)
        begin
            if ({1'b0, now} + {1'b0, dur} > 33'hFFFF_FFFF)
                res.rejected = 1'b1;
            else
            begin
                from_level = from_v;
                to_level = to_v;
                start_stamp = now;
                span = dur;
                idle_tween = 1'b0;
                res.value = from_v;
                res.written = 1'b1;
            end
        end
        else if (!idle_tween)
        begin
            elapsed = now - start_stamp;
            res.written = 1'b1;
            if (elapsed >= span)
            begin
                res.value = to_level;
                if (swap_ends)
                begin
                    held = from_level;
                    from_level = to_level;
                    to_level = held;
                end
                if (laps_left != 8'd1)
                begin
                    if (laps_left > 8'd1)
                        laps_left = laps_left - 8'd1;
                    start_stamp = now;
                    res.repeated = 1'b1;
                    res.running = 1'b1;
                end
                else
                begin
                    res.finished = 1'b1;
                    idle_tween = 1'b1;
                end
            end
            else
            begin
                ratio = longint'({elapsed, 16'h0000} / {16'h0000, span});
                val = longint'(from_level)
                      + fx_mul(longint'(to_level) - longint'(from_level),
                               eased_ratio(curve_mode, ratio));
                if (val > 32767)
                    val = 32767;
                if (val < -32768)
                    val = -32768;
                res.value = val[15:0];
                res.running = 1'b1;
            end
        end
        return res;
    endfunction

    assign pending = tween_results_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        tween_result_t want, got;
        if (!rst_n)
        begin
            curve_mode  <= MODE_LINEAR;
            swap_ends   <= 1'b0;
            from_level  = '0;
            to_level    = '0;
            start_stamp = '0;
            span        = '0;
            laps_left   = 8'd1;
            idle_tween  = 1'b1;
            fail_count  <= 0;
            tween_results_due.delete();
        end
        else
        begin
            // the user makes register writes only while idle; unenforced
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3:2] == REG_MODE)
                    curve_mode <= pwdata[3:0];
                else if (paddr[3:2] == REG_REVERSE)
                    swap_ends <= pwdata[0];
                else if (paddr[3:2] == REG_REPEAT)
                    laps_left = pwdata[7:0];
            end
            if (in_valid && in_ready)
                tween_results_due.push_back(advance_tween(req_type == REQ_START, now_ms,
                                                          from_value, to_value,
                                                          duration_ms));
            if (out_valid && out_ready)
            begin
                got = '{out_value, value_valid, still_running, repeat_event,
                        finish_event, start_rejected};
                if (tween_results_due.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = tween_results_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("result mismatch at %0t: expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives start and update requests plus apb register writes into the tween
// engine; a checker beside the engine predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
    import etw_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_GOAL   = 1400;
    localparam int SETTLE      = 80;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic        [31:0] now_ms;
    logic signed [15:0] from_value;
    logic signed [15:0] to_value;
    logic        [31:0] duration_ms;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] out_value;
    logic               value_valid;
    logic               still_running;
    logic               repeat_event;
    logic               finish_event;
    logic               start_rejected;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic        [3:0]  paddr;
    logic        [31:0] pwdata;
    logic        [31:0] prdata;
    logic               pready;

    int  fail_count;
    int  pending;
    int  cycles;
    int  sent;
    // when set neither side inserts idle cycles
    logic calm;

    easing_tween_engine DUT (.*);

    easing_tween_checker checker_i (
        .clk, .rst_n, .in_valid, .in_ready, .req_type, .now_ms, .from_value,
        .to_value, .duration_ms, .out_valid, .out_ready, .out_value, .value_valid,
        .still_running, .repeat_event, .finish_event, .start_rejected, .psel,
        .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver stalls on about 11 percent of cycles unless calm is set
    always @(negedge clk)
        out_ready = calm || ($urandom_range(0, 99) >= 11);

    // one request transfer; valid stays high into the next call when no gap
    task automatic send_request(logic kind, logic [31:0] now, logic signed [15:0] from_v,
                                logic signed [15:0] to_v, logic [31:0] dur);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        req_type    = kind;
        now_ms      = now;
        from_value  = from_v;
        to_value    = to_v;
        duration_ms = dur;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the write lands at the access edge
    task automatic apb_write(logic [1:0] index, logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic signed [15:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // a start followed by a run of updates that walks through the cycle ends
    task automatic play_tween();
        logic [31:0] t0, dur, now, step;
        int n;
        case ($urandom_range(0, 19))
            0:       dur = 0;
            1:       dur = $urandom;
            2:       dur = $urandom_range(1, 3);
            default: dur = $urandom_range(4, 400);
        endcase
        t0 = $urandom;
        if ({1'b0, t0} + {1'b0, dur} > 33'hFFFF_FFFF)
            t0 = 32'hFFFF_FFFF - dur;
        send_request(REQ_START, t0, pick_level(), pick_level(), dur);
        now = t0;
        n = $urandom_range(3, 14);
        for (int k = 0; k < n; k++)
        begin
            step = (dur > 400) ? $urandom : $urandom_range(0, dur / 4 + 1);
            now = ($urandom_range(0, 29) == 0) ? $urandom : now + step;
            send_request(~REQ_START, now, 16'($urandom), 16'($urandom), $urandom);
        end
    endtask

    initial
    begin
        logic [7:0] laps [5];
        int target;
        laps        = '{8'd1, 8'd0, 8'd3, 8'd255, 8'd2};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = 1'b0;
        now_ms      = '0;
        from_value  = '0;
        to_value    = '0;
        duration_ms = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        cycles      = 0;
        sent        = 0;
        out_ready   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: update while finished, overflow refusals, boundary starts,
        // zero duration, time going backwards and the value extremes
        send_request(~REQ_START, 32'd5, 16'sd0, 16'sd0, 32'd0);
        send_request(REQ_START, 32'hFFFF_FFFF, 16'sd1, 16'sd2, 32'd1);
        send_request(REQ_START, 32'h8000_0000, 16'sd1, 16'sd2, 32'h8000_0000);
        send_request(REQ_START, 32'hFFFF_FFFF, -16'sd32768, 16'sd32767, 32'd0);
        send_request(~REQ_START, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 32'd0);
        send_request(~REQ_START, 32'd0, 16'sd0, 16'sd0, 32'd0);
        send_request(REQ_START, 32'd0, 16'sd32767, -16'sd32768, 32'hFFFF_FFFF);
        send_request(~REQ_START, 32'h7FFF_FFFF, 16'sd0, 16'sd0, 32'd0);
        send_request(~REQ_START, 32'hFFFF_FFFE, 16'sd0, 16'sd0, 32'd0);
        send_request(~REQ_START, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 32'd0);
        send_request(REQ_START, 32'd1000, -16'sd32768, 16'sd32767, 32'd100);
        send_request(~REQ_START, 32'd999, 16'sd0, 16'sd0, 32'd0);
        wait_drained();

        // one phase per curve code, unused codes included, with mixed settings
        for (int p = 0; p < 16; p++)
        begin
            apb_write(REG_MODE, p);
            apb_write(REG_REVERSE, (p == 0) ? 0 : (p == 1) ? 1 : $urandom_range(0, 1));
            apb_write(REG_REPEAT, 32'(laps[p % 5]));
            calm = (p == 4);
            target = sent + (ITEM_GOAL / 16);
            while (sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(1'($urandom), $urandom, 16'($urandom), 16'($urandom),
                                 $urandom);
                else
                    play_tween();
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/etw_pkg.sv
rtl/etw_qmul.sv
rtl/easing_tween_engine.sv
tb/sv/easing_tween_checker.sv
tb/sv/testbench.sv
